@@ sv/assert_macros.svh @@
// Assertion macros shared by the rasterizer RTL.
// No dependencies; define SYNTH to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Check a property at each rising edge, held off while reset is active.
`define SFR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property at each rising edge, reset included.
`define SFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SFR_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ sv/sfr_pkg.sv @@
// Types, codes and fixed widths of the shape fill rasterizer.
// No dependencies; used by the scanner and the top level.
package sfr_pkg;

    // Fixed field widths
    localparam int COORD_W   = 9;   // image size registers and scan counters
    localparam int FIELD_W   = 10;  // center, size and radius fields
    localparam int CHAN_W    = 8;
    localparam int COLOR_W   = 3 * CHAN_W;
    localparam int PIX_W     = 8;   // read pixel coordinates
    localparam int DELTA_W   = 12;  // signed bounds and distances
    localparam int SQ_W      = 20;  // square of a distance or radius
    localparam int SUM_W     = SQ_W + 1;

    // Stream packing
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 24;
    localparam int OFS_CX    = 0;
    localparam int OFS_CY    = OFS_CX + FIELD_W;
    localparam int OFS_RW    = OFS_CY + FIELD_W;
    localparam int OFS_RH    = OFS_RW + FIELD_W;
    localparam int OFS_RAD   = OFS_RH + FIELD_W;
    localparam int OFS_RED   = OFS_RAD + FIELD_W;
    localparam int OFS_GREEN = OFS_RED + CHAN_W;
    localparam int OFS_BLUE  = OFS_GREEN + CHAN_W;
    localparam int OFS_PX    = OFS_BLUE + CHAN_W;
    localparam int OFS_PY    = OFS_PX + PIX_W;

    // Command codes carried on tuser
    typedef enum logic [1:0] {
        FUNC_RECT   = 2'd0,
        FUNC_CIRCLE = 2'd1,
        FUNC_READ   = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    // Configuration register indexes
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;
    localparam logic [COORD_W-1:0] IMAGE_SIZE_RESET = 9'd256;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_DRAW,
        ST_RD_ADDR,
        ST_RD_DATA
    } ctrl_state_t;

    // Draw command handed from the controller to the scanner
    typedef struct packed {
        logic                       is_circle;
        logic [COORD_W-1:0]         xs;
        logic [COORD_W-1:0]         xe;
        logic [COORD_W-1:0]         ys;
        logic [COORD_W-1:0]         ye;
        logic signed [FIELD_W-1:0]  cx;
        logic signed [FIELD_W-1:0]  cy;
        logic [SQ_W-1:0]            r2;
        logic [COLOR_W-1:0]         color;
    } scan_cmd_t;

    // Address bits for a memory of the given depth
    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

@@ sv/sfr_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module sfr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/sfr_scan.sv @@
// Pixel scanner: walks the clipped box of a draw command and writes hits.
// Depends on sfr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfr_scan
    import sfr_pkg::*;
#(
    parameter int MAX_WIDTH = 256,
    parameter int DEPTH     = 65536
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  scan_cmd_t                   cmd,
    output logic                        busy,
    output logic                        we,
    output logic [addr_bits(DEPTH)-1:0] waddr,
    output logic [COLOR_W-1:0]          wdata
);

    localparam int AW = addr_bits(DEPTH);
    localparam int PW = AW + COORD_W;

    scan_cmd_t                 cmd_reg;
    logic [COORD_W-1:0]        x_reg, x_next;
    logic [COORD_W-1:0]        y_reg, y_next;
    logic                      run_reg, run_next;
    logic                      x_last, y_last;

    logic                      va_reg;
    logic signed [DELTA_W-1:0] dxa_reg, dxa_next;
    logic signed [DELTA_W-1:0] dya_reg, dya_next;
    logic [AW-1:0]             addra_reg;
    logic [PW-1:0]             addr_prod;

    logic                      vb_reg;
    logic signed [2*DELTA_W-1:0] dx_prod, dy_prod;
    logic [SQ_W-1:0]           dx2_reg, dy2_reg;
    logic [AW-1:0]             addrb_reg;

    logic [SUM_W-1:0]          dist_sum;
    logic                      hit;
    logic                      we_reg;
    logic [AW-1:0]             waddr_reg;

    // Latch the command at start
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg <= cmd;
        end
    end

    // Advance the scan position, row by row
    assign x_last = ({1'b0, x_reg} + 1'b1) == {1'b0, cmd_reg.xe};
    assign y_last = ({1'b0, y_reg} + 1'b1) == {1'b0, cmd_reg.ye};

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        run_next = run_reg;
        priority if (start)
        begin
            x_next   = cmd.xs;
            y_next   = cmd.ys;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (x_last)
            begin
                x_next = cmd_reg.xs;
                if (y_last)
                begin
                    y_next   = '0;
                    run_next = 1'b0;
                end
                else
                begin
                    y_next = y_reg + 1'b1;
                end
            end
            else
            begin
                x_next = x_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg   <= '0;
            y_reg   <= '0;
            run_reg <= 1'b0;
        end
        else
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            run_reg <= run_next;
        end
    end

    // Stage A: offsets from the center and the store address
    assign dxa_next  = $signed(DELTA_W'(x_reg)) - DELTA_W'($signed(cmd_reg.cx));
    assign dya_next  = $signed(DELTA_W'(y_reg)) - DELTA_W'($signed(cmd_reg.cy));
    assign addr_prod = PW'(y_reg) * PW'(MAX_WIDTH) + PW'(x_reg);

    always_ff @(posedge clk)
    begin
        dxa_reg   <= dxa_next;
        dya_reg   <= dya_next;
        addra_reg <= addr_prod[AW-1:0];
    end

    // Stage B: squares of the offsets
    assign dx_prod = (2*DELTA_W)'(dxa_reg) * (2*DELTA_W)'(dxa_reg);
    assign dy_prod = (2*DELTA_W)'(dya_reg) * (2*DELTA_W)'(dya_reg);

    always_ff @(posedge clk)
    begin
        dx2_reg   <= dx_prod[SQ_W-1:0];
        dy2_reg   <= dy_prod[SQ_W-1:0];
        addrb_reg <= addra_reg;
    end

    // Stage C: radius test, then register the write
    assign dist_sum = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign hit      = !cmd_reg.is_circle || (dist_sum <= {1'b0, cmd_reg.r2});

    always_ff @(posedge clk)
    begin
        waddr_reg <= addrb_reg;
    end

    // Valid flags of the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            we_reg <= 1'b0;
        end
        else
        begin
            va_reg <= run_reg;
            vb_reg <= va_reg;
            we_reg <= vb_reg && hit;
        end
    end

    assign busy  = run_reg || va_reg || vb_reg || we_reg;
    assign we    = we_reg;
    assign waddr = waddr_reg;
    assign wdata = cmd_reg.color;

    `SFR_ASSERT(a_waddr_in_store, clk, rst_n, we_reg |-> ({1'b0, waddr_reg} < (AW+1)'(DEPTH)), "scanner write beyond the store")
    `SFR_ASSERT(a_scan_in_box, clk, rst_n, run_reg |-> (x_reg < cmd_reg.xe && y_reg < cmd_reg.ye), "scan position left the box")
    `SFR_ASSERT(a_start_when_idle, clk, rst_n, start |-> !busy, "draw started while scanner busy")

endmodule

@@ sv/shape_fill_rasterizer.sv @@
// Shape fill rasterizer: RGB framebuffer of MAX_WIDTH x MAX_HEIGHT pixels held in
// one synchronous RAM, with rectangle fill, circle fill and pixel read commands.
// One command is handled at a time. Timing is set by the single RAM write port,
// which takes one pixel per cycle, and by the three-stage scanner behind it. A
// rectangle scans its clipped box and writes nothing when that box is empty; a
// circle scans every pixel of the image in use, the image width times the image
// height; a read waits while an earlier result is still held in the result
// register; an ignored command is accepted and dropped.
// After reset, a clearing pass writes black to all MAX_WIDTH*MAX_HEIGHT entries
// with s_tready low; configuration writes are taken meanwhile.
// Depends on sfr_pkg, sfr_ram, sfr_scan and assert_macros.svh.
`include "assert_macros.svh"

module shape_fill_rasterizer
    import sfr_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // Command stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // cx[9:0], cy[19:10], rect_width[29:20], rect_height[39:30],
    // radius[49:40], red[57:50], green[65:58], blue[73:66], pixel_x[81:74],
    // pixel_y[89:82], zero fill[95:90]
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    // func[1:0]
    input  logic [1:0]              s_tuser,
    // Result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    // Configuration writes
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [COORD_W-1:0]      cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = addr_bits(DEPTH);
    localparam int PW    = AW + COORD_W;
    localparam int W_CAP = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
    localparam int H_CAP = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;

    ctrl_state_t               state_reg, state_next;
    func_t                     func_in;

    logic [COORD_W-1:0]        img_w_reg, img_h_reg;
    logic [COORD_W-1:0]        used_w, used_h;

    logic signed [FIELD_W-1:0] cx_reg, cy_reg;
    logic [FIELD_W-1:0]        rw_reg, rh_reg, rad_reg;
    logic [COLOR_W-1:0]        color_reg;
    logic [PIX_W-1:0]          px_reg, py_reg;
    logic                      is_circle_reg;
    logic                      rd_ok_reg;
    logic                      accept;

    logic [AW-1:0]             clr_reg;

    logic signed [DELTA_W-1:0] cx_s, cy_s, half_w, half_h;
    logic signed [DELTA_W-1:0] x0, x1, y0, y1, rxs, rxe, rys, rye, iw_s, ih_s;
    logic                      rect_empty, circ_empty, draw_empty;
    logic [SQ_W-1:0]           r2;
    scan_cmd_t                 scan_cmd;
    logic                      scan_start, scan_busy, scan_we;
    logic [AW-1:0]             scan_waddr;
    logic [COLOR_W-1:0]        scan_wdata;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [COLOR_W-1:0]        ram_wdata;
    logic                      rd_en;
    logic [PW-1:0]             rd_prod;
    logic [COLOR_W-1:0]        rd_data;

    logic                      out_load;
    logic                      out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0]    out_data_reg;

    assign func_in = func_t'(s_tuser);
    assign accept  = s_tvalid && s_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            img_w_reg <= IMAGE_SIZE_RESET;
            img_h_reg <= IMAGE_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  img_w_reg <= cfg_data;
                CFG_IMAGE_HEIGHT: img_h_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Clamp the image size to the store
    assign used_w = (img_w_reg > COORD_W'(W_CAP)) ? COORD_W'(W_CAP) : img_w_reg;
    assign used_h = (img_h_reg > COORD_W'(H_CAP)) ? COORD_W'(H_CAP) : img_h_reg;

    // Hold the fields of the accepted transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg        <= $signed(s_tdata[OFS_CX +: FIELD_W]);
            cy_reg        <= $signed(s_tdata[OFS_CY +: FIELD_W]);
            rw_reg        <= s_tdata[OFS_RW +: FIELD_W];
            rh_reg        <= s_tdata[OFS_RH +: FIELD_W];
            rad_reg       <= s_tdata[OFS_RAD +: FIELD_W];
            color_reg     <= {s_tdata[OFS_RED +: CHAN_W], s_tdata[OFS_GREEN +: CHAN_W],
                              s_tdata[OFS_BLUE +: CHAN_W]};
            px_reg        <= s_tdata[OFS_PX +: PIX_W];
            py_reg        <= s_tdata[OFS_PY +: PIX_W];
            is_circle_reg <= (func_in == FUNC_CIRCLE);
            rd_ok_reg     <= (COORD_W'(s_tdata[OFS_PX +: PIX_W]) < used_w) &&
                             (COORD_W'(s_tdata[OFS_PY +: PIX_W]) < used_h);
        end
    end

    // Rectangle bounds, clipped on all four sides
    assign cx_s   = DELTA_W'(cx_reg);
    assign cy_s   = DELTA_W'(cy_reg);
    assign half_w = $signed(DELTA_W'(rw_reg >> 1));
    assign half_h = $signed(DELTA_W'(rh_reg >> 1));
    assign iw_s   = $signed(DELTA_W'(used_w));
    assign ih_s   = $signed(DELTA_W'(used_h));
    assign x0     = cx_s - half_w;
    assign x1     = cx_s + half_w;
    assign y0     = cy_s - half_h;
    assign y1     = cy_s + half_h;
    assign rxs    = (x0 < 0) ? '0 : x0;
    assign rxe    = (x1 > iw_s) ? iw_s : x1;
    assign rys    = (y0 < 0) ? '0 : y0;
    assign rye    = (y1 > ih_s) ? ih_s : y1;

    assign rect_empty = (rxe <= rxs) || (rye <= rys);
    assign circ_empty = (used_w == '0) || (used_h == '0);
    assign draw_empty = is_circle_reg ? circ_empty : rect_empty;
    assign r2         = SQ_W'(rad_reg) * SQ_W'(rad_reg);

    // Build the scanner command; a circle scans the whole image
    always_comb
    begin
        scan_cmd.is_circle = is_circle_reg;
        scan_cmd.cx        = cx_reg;
        scan_cmd.cy        = cy_reg;
        scan_cmd.r2        = r2;
        scan_cmd.color     = color_reg;
        if (is_circle_reg)
        begin
            scan_cmd.xs = '0;
            scan_cmd.xe = used_w;
            scan_cmd.ys = '0;
            scan_cmd.ye = used_h;
        end
        else
        begin
            scan_cmd.xs = COORD_W'(rxs);
            scan_cmd.xe = COORD_W'(rxe);
            scan_cmd.ys = COORD_W'(rys);
            scan_cmd.ye = COORD_W'(rye);
        end
    end

    // Controller state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and controls
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        scan_start = 1'b0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    unique case (func_in)
                        FUNC_RECT,
                        FUNC_CIRCLE: state_next = ST_SETUP;
                        FUNC_READ:   state_next = ST_RD_ADDR;
                        FUNC_NONE:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SETUP:
            begin
                if (draw_empty)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    scan_start = 1'b1;
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                if (!scan_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RD_ADDR:
            begin
                rd_en      = rd_ok_reg;
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (state_reg == ST_CLEAR)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    sfr_scan #(
        .MAX_WIDTH (MAX_WIDTH),
        .DEPTH     (DEPTH)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .cmd   (scan_cmd),
        .busy  (scan_busy),
        .we    (scan_we),
        .waddr (scan_waddr),
        .wdata (scan_wdata)
    );

    // Write port: clearing pass first, then scanner
    assign ram_we    = (state_reg == ST_CLEAR) || scan_we;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_reg : scan_waddr;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : scan_wdata;

    // Read address of the pixel
    assign rd_prod = PW'(py_reg) * PW'(MAX_WIDTH) + PW'(px_reg);

    sfr_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (rd_en),
        .raddr (rd_prod[AW-1:0]),
        .rdata (rd_data)
    );

    // Output register: a pixel outside the image reads as black
    assign out_valid_next = out_load || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= rd_ok_reg ?
                {rd_data[0 +: CHAN_W], rd_data[CHAN_W +: CHAN_W], rd_data[2*CHAN_W +: CHAN_W]} :
                '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `SFR_ASSERT_ALWAYS(a_no_read_during_draw, clk, !(rd_en && scan_we), "frame read overlaps a draw write")
    `SFR_ASSERT(a_result_from_read, clk, rst_n, $rose(m_tvalid) |-> ($past(state_reg) == ST_RD_DATA), "result without a read command")
    `SFR_ASSERT(a_clear_alone, clk, rst_n, (state_reg == ST_CLEAR) |-> !scan_busy, "scanner active during clearing pass")

endmodule
